// ===== src/mi4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants, types and arithmetic helpers for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAT_ELEMS = 16;

   localparam logic [127:0] LIM_WIDE = 128'd1 << 63;
   localparam logic [127:0] LIM_WORD = 128'd1 << (WORD_BITS - 1);
   localparam logic [127:0] HALF_Q   = 128'd1 << (FRAC_BITS - 1);
   localparam logic [127:0] HALF_R   = 128'd1 << (62 - FRAC_BITS);
   localparam logic [63:0]  INT_MAX  = {1'b0, {63{1'b1}}};
   localparam logic [63:0]  INT_MIN  = {1'b1, 63'd0};

   // element write from the loader into the matrix queue
   typedef struct packed {
      logic                 en;
      logic [3:0]           idx;
      logic                 last;
      logic [WORD_BITS-1:0] data;
   } mi4_wr_type;

   // read request from the compute engine into the matrix queue
   typedef struct packed {
      logic       pop;
      logic [3:0] idx;
   } mi4_rd_type;

   function automatic logic [63:0] sext_word(input logic [WORD_BITS-1:0] w);
      return {{(64-WORD_BITS){w[WORD_BITS-1]}}, w};
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] sat_neg(input logic [63:0] a);
      return (a == INT_MIN) ? INT_MAX : (64'd0 - a);
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? INT_MIN : INT_MAX;
      end
      return s;
   endfunction

   // sign and magnitude to a signed value clamped at the given limit
   function automatic logic [63:0] sat_mag(input logic neg, input logic [127:0] m,
                                           input logic [127:0] lim);
      logic [63:0] v;
      if (neg) begin
         v = (m > lim) ? lim[63:0] : m[63:0];
         return 64'd0 - v;
      end
      return (m >= lim) ? (lim[63:0] - 64'd1) : m[63:0];
   endfunction

   // column picked in minor row r by term t of the 3x3 expansion
   function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] r);
      logic [5:0] pr;
      case (t)
         3'd0:    pr = {2'd2, 2'd1, 2'd0};
         3'd1:    pr = {2'd1, 2'd2, 2'd0};
         3'd2:    pr = {2'd2, 2'd0, 2'd1};
         3'd3:    pr = {2'd0, 2'd2, 2'd1};
         3'd4:    pr = {2'd1, 2'd0, 2'd2};
         3'd5:    pr = {2'd0, 2'd1, 2'd2};
         default: pr = 6'd0;
      endcase
      case (r)
         2'd0:    return pr[1:0];
         2'd1:    return pr[3:2];
         default: return pr[5:4];
      endcase
   endfunction

   function automatic logic perm_neg(input logic [2:0] t);
      return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
   endfunction

   // matrix index of factor r of term t for adjugate entry k
   function automatic logic [3:0] elem_idx(input logic [3:0] k, input logic [2:0] t,
                                           input logic [1:0] r);
      logic [1:0] p;
      logic [1:0] row;
      logic [1:0] col;
      p   = perm_col(t, r);
      row = (r < k[1:0]) ? r : (r + 2'd1);
      col = (p < k[3:2]) ? p : (p + 2'd1);
      return {row, col};
   endfunction

endpackage

// ===== src/mi4_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_front
// Element loader: counts incoming elements and tags each with its position.
// ----------------------------------------------------------------------------
module mi4_front import mi4_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_element,
   input  logic                 wr_free,
   output mi4_wr_type           wr
);

   logic [3:0] count_ff;

   // tag and forward one element per accepted transaction
   always_comb begin
      req_ready = wr_free;
      wr.en     = req_valid && wr_free;
      wr.idx    = count_ff;
      wr.last   = (count_ff == 4'd15);
      wr.data   = req_element;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else if (wr.en) begin
         count_ff <= count_ff + 4'd1;
      end
   end

endmodule

// ===== src/mi4_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_fifo
// Two-slot matrix queue between loader and compute engine, random read.
// ----------------------------------------------------------------------------
module mi4_fifo import mi4_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mi4_wr_type           wr,
   output logic                 wr_free,
   input  mi4_rd_type           rd,
   output logic                 mat_ready,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [0:2*MAT_ELEMS-1];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [1:0]           full_ff;
   logic [1:0]           full_in;
   logic                 wr_slot_ff;
   logic                 rd_slot_ff;

   assign wr_free   = !full_ff[wr_slot_ff];
   assign mat_ready = full_ff[rd_slot_ff];
   assign rd_data   = rd_data_ff;

   // storage, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr_slot_ff, wr.idx}] <= wr.data;
      end
      rd_data_ff <= mem[{rd_slot_ff, rd.idx}];
   end

   // slot flags: set on the last element, cleared on pop
   always_comb begin
      full_in = full_ff;
      if (wr.en && wr.last) begin
         full_in[wr_slot_ff] = 1'b1;
      end
      if (rd.pop) begin
         full_in[rd_slot_ff] = 1'b0;
      end
   end

   // slot bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff    <= 2'b00;
         wr_slot_ff <= 1'b0;
         rd_slot_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         if (wr.en && wr.last) begin
            wr_slot_ff <= !wr_slot_ff;
         end
         if (rd.pop) begin
            rd_slot_ff <= !rd_slot_ff;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !full_ff[wr_slot_ff]) else $error("write into a full slot");
   a_pop_full: assert property (@(posedge clock) disable iff (reset)
      rd.pop |-> full_ff[rd_slot_ff]) else $error("pop of an empty slot");
   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      rd.pop |=> !full_ff[$past(rd_slot_ff)]) else $error("popped slot still full");
`endif

endmodule

// ===== src/mi4_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_mul
// 64x64 unsigned multiplier: four 32x32 partial products.
// ----------------------------------------------------------------------------
module mi4_mul (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic          done,
   output logic [127:0]  prod
);

   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   psh_ff;
   logic [127:0] acc_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [31:0]  a_part;
   logic [31:0]  b_part;

   assign a_part = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_part = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign done   = done_ff;
   assign prod   = acc_ff;

   // partial product computed into a register, then accumulated in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            b_ff    <= b;
            acc_ff  <= 128'd0;
            step_ff <= 3'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (step_ff != 3'd4) begin
               pp_ff  <= a_part * b_part;
               psh_ff <= {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            end
            if (step_ff != 3'd0) begin
               acc_ff <= acc_ff + ({64'd0, pp_ff} << {psh_ff, 5'd0});
            end
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 3'd1;
         end
      end
   end

endmodule

// ===== src/mi4_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_back
// Compute engine: cofactors, determinant, reciprocal and scaled inverse.
// ----------------------------------------------------------------------------
module mi4_back import mi4_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 mat_ready,
   input  logic [WORD_BITS-1:0] rd_data,
   output mi4_rd_type           rd,
   output logic                 mul_start,
   output logic [63:0]          mul_a,
   output logic [63:0]          mul_b,
   input  logic                 mul_done,
   input  logic [127:0]         mul_prod,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_inverse_element,
   output logic                 rsp_singular,
   output logic                 rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE, S_RX, S_LX, S_LY, S_LZ, S_MW, S_SAT, S_ACC, S_ADJ,
      S_DRD, S_DL, S_CHK, S_DIV, S_ORD, S_OL, S_EMIT
   } state_type;

   typedef enum logic [1:0] {PH_XY, PH_TERM, PH_DET, PH_OUT} phase_type;

   state_type            state_ff;
   phase_type            phase_ff;
   logic [3:0]           k_ff;
   logic [2:0]           t_ff;
   logic [5:0]           cnt_ff;
   logic [63:0]          opa_ff;
   logic [63:0]          val_ff;
   logic [63:0]          acc_ff;
   logic [127:0]         rnd_ff;
   logic                 neg_ff;
   logic                 dneg_ff;
   logic                 sing_ff;
   logic [63:0]          dsor_ff;
   logic [63:0]          rem_ff;
   logic [63:0]          quo_ff;
   logic [63:0]          adj_mem [0:MAT_ELEMS-1];
   logic [63:0]          adj_rd_ff;
   logic [3:0]           adj_raddr;
   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_elem_ff;
   logic                 rsp_sing_ff;
   logic                 rsp_last_ff;

   logic [63:0]  rd_wide;
   logic [63:0]  sat_val;
   logic [63:0]  term;
   logic [64:0]  rem_sh;
   logic         out_free;
   logic         emit_last;

   assign rd_wide   = sext_word(rd_data);
   assign sat_val   = sat_mag(neg_ff, rnd_ff, (phase_ff == PH_OUT) ? LIM_WORD : LIM_WIDE);
   assign term      = perm_neg(t_ff) ? sat_neg(val_ff) : val_ff;
   assign rem_sh    = {rem_ff, cnt_ff == 6'd0};
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = sing_ff || (k_ff == 4'd15);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inverse_element = rsp_elem_ff;
   assign rsp_singular        = rsp_sing_ff;
   assign rsp_last            = rsp_last_ff;

   // read addresses and multiplier operands
   always_comb begin
      rd.idx    = 4'd0;
      rd.pop    = (state_ff == S_EMIT) && out_free && emit_last;
      adj_raddr = k_ff;
      mul_start = 1'b0;
      mul_a     = mag64(opa_ff);
      mul_b     = mag64(rd_wide);
      case (state_ff)
         S_RX:  rd.idx = elem_idx(k_ff, t_ff, 2'd0);
         S_LX:  rd.idx = elem_idx(k_ff, t_ff, 2'd1);
         S_SAT: rd.idx = elem_idx(k_ff, t_ff, 2'd2);
         S_DRD: begin
            rd.idx    = {2'b00, k_ff[1:0]};
            adj_raddr = {k_ff[1:0], 2'b00};
         end
         S_LY, S_LZ: mul_start = 1'b1;
         S_DL: begin
            mul_start = 1'b1;
            mul_a     = mag64(rd_wide);
            mul_b     = mag64(adj_rd_ff);
         end
         S_OL: begin
            mul_start = 1'b1;
            mul_a     = mag64(adj_rd_ff);
            mul_b     = quo_ff;
         end
         default: ;
      endcase
   end

   // adjugate store, registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_ADJ) begin
         adj_mem[k_ff] <= (k_ff[2] ^ k_ff[0]) ? sat_neg(acc_ff) : acc_ff;
      end
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_XY;
         k_ff         <= 4'd0;
         t_ff         <= 3'd0;
         cnt_ff       <= 6'd0;
         sing_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result is loaded only from the emit state
         if (rsp_ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (mat_ready) begin
                  k_ff     <= 4'd0;
                  t_ff     <= 3'd0;
                  acc_ff   <= 64'd0;
                  state_ff <= S_RX;
               end
            end
            S_RX: state_ff <= S_LX;
            S_LX: begin
               opa_ff   <= rd_wide;
               state_ff <= S_LY;
            end
            S_LY: begin
               neg_ff   <= opa_ff[63] ^ rd_wide[63];
               phase_ff <= PH_XY;
               state_ff <= S_MW;
            end
            S_LZ: begin
               neg_ff   <= opa_ff[63] ^ rd_wide[63];
               phase_ff <= PH_TERM;
               state_ff <= S_MW;
            end
            S_MW: begin
               if (mul_done) begin
                  if (phase_ff == PH_OUT) begin
                     rnd_ff <= (mul_prod + HALF_R) >> (63 - FRAC_BITS);
                  end else begin
                     rnd_ff <= (mul_prod + HALF_Q) >> FRAC_BITS;
                  end
                  state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               val_ff <= sat_val;
               opa_ff <= sat_val;
               case (phase_ff)
                  PH_XY:   state_ff <= S_LZ;
                  PH_OUT:  state_ff <= S_EMIT;
                  default: state_ff <= S_ACC;
               endcase
            end
            S_ACC: begin
               if (phase_ff == PH_TERM) begin
                  acc_ff <= sat_add(acc_ff, term);
                  if (t_ff == 3'd5) begin
                     state_ff <= S_ADJ;
                  end else begin
                     t_ff     <= t_ff + 3'd1;
                     state_ff <= S_RX;
                  end
               end else begin
                  acc_ff <= sat_add(acc_ff, val_ff);
                  if (k_ff == 4'd3) begin
                     state_ff <= S_CHK;
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     state_ff <= S_DRD;
                  end
               end
            end
            S_ADJ: begin
               t_ff   <= 3'd0;
               acc_ff <= 64'd0;
               k_ff   <= k_ff + 4'd1;
               state_ff <= (k_ff == 4'd15) ? S_DRD : S_RX;
            end
            S_DRD: state_ff <= S_DL;
            S_DL: begin
               neg_ff   <= rd_wide[63] ^ adj_rd_ff[63];
               phase_ff <= PH_DET;
               state_ff <= S_MW;
            end
            S_CHK: begin
               dneg_ff <= acc_ff[63];
               dsor_ff <= mag64(acc_ff);
               rem_ff  <= 64'd0;
               quo_ff  <= 64'd0;
               cnt_ff  <= 6'd0;
               if (acc_ff == 64'd0) begin
                  sing_ff  <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // restoring division of 2^63 by |det|, one quotient bit a cycle
               if (rem_sh >= {1'b0, dsor_ff}) begin
                  rem_ff <= rem_sh[63:0] - dsor_ff;
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  k_ff     <= 4'd0;
                  state_ff <= S_ORD;
               end
            end
            S_ORD: state_ff <= S_OL;
            S_OL: begin
               neg_ff   <= adj_rd_ff[63] ^ dneg_ff;
               phase_ff <= PH_OUT;
               state_ff <= S_MW;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_elem_ff  <= sing_ff ? '0 : val_ff[WORD_BITS-1:0];
                  rsp_sing_ff  <= sing_ff;
                  rsp_last_ff  <= emit_last;
                  if (emit_last) begin
                     sing_ff  <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     state_ff <= S_ORD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== src/matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 fixed-point matrix inverse by adjugate, determinant and reciprocal.
//
//   channel   ports                                    direction
//   req       req_valid/ready, req_element             in, one element
//   rsp       rsp_valid/ready, rsp_inverse_element,    out, 16 results or
//             rsp_singular, rsp_last                   one singular result
//
// Elements load at one per cycle, while the queue has a free slot, into a
// two-matrix queue, so a new matrix loads while the previous one is computed.
// Computation time is set by the shared 64x64 multiplier (two products for
// each of 96 cofactor terms, four for the determinant, sixteen for the
// outputs) and the reciprocal divider.
// Reset is synchronous and clears all control state. Either side may stall.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 import mi4_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_element,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_inverse_element,
   output logic                 rsp_singular,
   output logic                 rsp_last
);

   mi4_wr_type           wr;
   mi4_rd_type           rd;
   logic                 wr_free;
   logic                 mat_ready;
   logic [WORD_BITS-1:0] rd_data;
   logic                 mul_start;
   logic [63:0]          mul_a;
   logic [63:0]          mul_b;
   logic                 mul_done;
   logic [127:0]         mul_prod;

   mi4_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_element, .wr_free, .wr
   );

   mi4_fifo u_fifo (
      .clock, .reset, .wr, .wr_free, .rd, .mat_ready, .rd_data
   );

   mi4_mul u_mul (
      .clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_prod)
   );

   mi4_back u_back (
      .clock, .reset, .mat_ready, .rd_data, .rd,
      .mul_start, .mul_a, .mul_b, .mul_done, .mul_prod,
      .rsp_valid, .rsp_ready, .rsp_inverse_element, .rsp_singular, .rsp_last
   );

endmodule

// ===== tb/tb_matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_4x4
// Self-checking bench for the 4x4 fixed-point matrix inverse. Matrices go in
// one element per transaction; a local adjugate/determinant/reciprocal model or a
// literal expectation predicts every result, checked field by field in order.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_4x4;
   import mi4_pkg::*;

   localparam int N_RAND_MAT = 15;
   localparam int WDOG_LIMIT = 20000;

   typedef struct {
      logic [WORD_BITS-1:0] inv;
      logic                 sing;
      logic                 last;
   } inv_result_type;

   // where the expectation of a directed row comes from
   typedef enum int {EXP_MODEL, EXP_IDENT, EXP_SING} exp_kind_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [WORD_BITS-1:0] req_element = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WORD_BITS-1:0] rsp_inverse_element;
   logic                 rsp_singular;
   logic                 rsp_last;

   inv_result_type expected_q[$];
   logic [63:0]  mat_shadow[16];
   int           elem_cnt = 0;
   bit           failed = 0;
   bit           use_model = 1;
   int           send_idle = 37;
   int           recv_idle = 81;
   int           idle_cycles = 0;

   matrix_inverse_4x4 dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = ({64'd0, mag64(a)} * {64'd0, mag64(b)} + HALF_Q) >> FRAC_BITS;
      if (a[63] != b[63]) return (p > LIM_WIDE) ? INT_MIN : 64'd0 - p[63:0];
      return (p >= LIM_WIDE) ? INT_MAX : p[63:0];
   endfunction

   // adjugate entry (i,j) = signed cofactor of element (j,i)
   function automatic logic [63:0] adj_entry(int i, int j);
      int rows[3], cols[3], perm[6][3], nr, nc;
      bit neg[6];
      logic [63:0] acc, t;
      perm = '{'{0,1,2}, '{0,2,1}, '{1,0,2}, '{1,2,0}, '{2,0,1}, '{2,1,0}};
      neg = '{0, 1, 1, 0, 0, 1};
      nr = 0; nc = 0; acc = 0;
      for (int k = 0; k < 4; k++) begin
         if (k != j) begin rows[nr] = k; nr++; end
         if (k != i) begin cols[nc] = k; nc++; end
      end
      for (int k = 0; k < 6; k++) begin
         t = fx_mul(fx_mul(mat_shadow[rows[0]*4 + cols[perm[k][0]]],
                           mat_shadow[rows[1]*4 + cols[perm[k][1]]]),
                    mat_shadow[rows[2]*4 + cols[perm[k][2]]]);
         acc = sat_add(acc, neg[k] ? sat_neg(t) : t);
      end
      return ((i + j) % 2) ? sat_neg(acc) : acc;
   endfunction

   function automatic void predict_inverse();
      logic [63:0]  adj[16];
      logic [63:0]  det, recip, v;
      logic [127:0] p;
      inv_result_type r;
      det = 0;
      for (int k = 0; k < 16; k++) adj[k] = adj_entry(k / 4, k % 4);
      for (int k = 0; k < 4; k++) det = sat_add(det, fx_mul(mat_shadow[k], adj[k*4]));
      if (det == 0) begin
         r = '{inv: '0, sing: 1'b1, last: 1'b1};
         expected_q.push_back(r);
         return;
      end
      recip = (64'd1 << 63) / mag64(det);
      for (int k = 0; k < 16; k++) begin
         p = ({64'd0, mag64(adj[k])} * {64'd0, recip} + (128'd1 << (62 - FRAC_BITS)))
             >> (63 - FRAC_BITS);
         v      = sat_mag(adj[k][63] != det[63], p, LIM_WORD);
         r.inv  = v[WORD_BITS-1:0];
         r.sing = 1'b0;
         r.last = (k == 15);
         expected_q.push_back(r);
      end
   endfunction

   // literal expectations: identity inverts to itself, zero matrix is singular
   function automatic void push_literal(exp_kind_type kind);
      inv_result_type r;
      if (kind == EXP_SING) begin
         r = '{inv: '0, sing: 1'b1, last: 1'b1};
         expected_q.push_back(r);
         return;
      end
      for (int k = 0; k < 16; k++) begin
         r.inv  = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
         r.sing = 1'b0;
         r.last = (k == 15);
         expected_q.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- driver
   task automatic send_element(logic [WORD_BITS-1:0] e);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_element <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mat_shadow[elem_cnt] = sext_word(e);
      if (elem_cnt == 15 && use_model) predict_inverse();
      elem_cnt = (elem_cnt + 1) % 16;
      @(negedge clock);
   endtask

   task automatic send_matrix(logic [WORD_BITS-1:0] m[16]);
      for (int k = 0; k < 16; k++) send_element(m[k]);
   endtask

   // random matrix: mostly modest values near identity, some full-range noise
   task automatic send_random_matrix();
      logic [WORD_BITS-1:0] m[16];
      int mode;
      mode = $urandom_range(9);
      for (int k = 0; k < 16; k++) begin
         if (mode < 6)
            m[k] = ((k % 5 == 0) ? 32'h0001_0000 : 32'h0) +
                   32'($signed($urandom_range(131072)) - 65536);
         else if (mode < 8)
            m[k] = 32'($signed($urandom_range(2097152)) - 1048576);
         else
            m[k] = $urandom;
      end
      send_matrix(m);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // result check at the rising edge
   always @(posedge clock) begin
      inv_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result inverse_element=%h", rsp_inverse_element);
            failed = 1;
         end else begin
            e = expected_q.pop_front();
            if (rsp_inverse_element !== e.inv) begin
               $error("inverse_element exp %h got %h", e.inv, rsp_inverse_element);
               failed = 1;
            end
            if (rsp_singular !== e.sing) begin
               $error("singular exp %b got %b", e.sing, rsp_singular);
               failed = 1;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %b got %b", e.last, rsp_last);
               failed = 1;
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
         $display("[matrix_inverse_4x4] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   logic [WORD_BITS-1:0] dir_tab[5][16];
   exp_kind_type         dir_exp[5];
   logic [WORD_BITS-1:0] row_m[16];

   initial begin
      // identity, 2*identity, zero (singular), max, min/alternating
      dir_tab[0] = '{32'h10000,0,0,0, 0,32'h10000,0,0, 0,0,32'h10000,0, 0,0,0,32'h10000};
      dir_tab[1] = '{32'h20000,0,0,0, 0,32'h20000,0,0, 0,0,32'h20000,0, 0,0,0,32'h20000};
      dir_tab[2] = '{default: 32'h0};
      dir_tab[3] = '{32'h7fffffff,0,0,0, 0,32'h7fffffff,0,0,
                     0,0,32'h7fffffff,0, 0,0,0,32'h7fffffff};
      dir_tab[4] = '{32'h80000000,32'hffffffff,1,32'h7fffffff,
                     1,32'h80000000,32'hffffffff,0, 0,1,32'h80000000,32'h55555555,
                     32'haaaaaaaa,0,1,32'h80000000};
      dir_exp = '{EXP_IDENT, EXP_MODEL, EXP_SING, EXP_MODEL, EXP_MODEL};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identity checked against the literal expectation first
      for (int t = 0; t < 5; t++) begin
         row_m     = dir_tab[t];
         use_model = (dir_exp[t] == EXP_MODEL);
         send_matrix(row_m);
         if (!use_model) push_literal(dir_exp[t]);
         if (t == 0) drain();
      end
      use_model = 1;
      drain();   // sender holds until every result is back

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle = 81; recv_idle = 37; end
         if (ph == 2) begin send_idle = 0;  recv_idle = 0;  end
         for (int n = 0; n < N_RAND_MAT / 3; n++) send_random_matrix();
      end
      drain();

      if (!failed && expected_q.size() == 0) begin
         $display("[matrix_inverse_4x4] OK");
      end else begin
         $display("[matrix_inverse_4x4] ERROR");
      end
      $finish;
   end

endmodule
